// ===== design/lj_pkg.sv =====
// ----------------------------------------------------------------------------
// lj_pkg: shared types and constants of the pair force block
// Register indexes, reset values, queue entry layout and pipeline figures.
// ----------------------------------------------------------------------------
package lj_pkg;

   // Fixed-point fraction bits at the default setting.
   localparam int LJ_FRAC_BITS = 16;

   // Field widths fixed by the interface.
   localparam int POS_W   = 32;
   localparam int SIGMA_W = 24;
   localparam int EPS_W   = 24;
   localparam int FORCE_W = 32;
   localparam int CSR_IDX_W = 3;

   // Queue between front and back.
   localparam int LJ_QUEUE_DEPTH = 4;

   // Arithmetic units.
   localparam int WORD_W = 64;
   localparam int MUL_LAT = 2;
   localparam int FORCE_QW = 33;

   // Register reset values.
   localparam logic [31:0] BOX_RESET    = 32'd655360;
   localparam logic [31:0] THR_RESET    = 32'd98304;
   localparam logic [31:0] CUTOFF_RESET = 32'd98304;
   localparam logic [23:0] EPS_RESET    = 24'd98304;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_X     = 3'd0,
      CSR_BOX_Y     = 3'd1,
      CSR_BOX_Z     = 3'd2,
      CSR_THRESHOLD = 3'd3,
      CSR_CUTOFF    = 3'd4,
      CSR_EPSILON   = 3'd5
   } csr_index_type;

   // One classified pair as it travels from front to back.
   typedef struct packed {
      logic [2:0][31:0]    mag;
      logic [2:0]          neg;
      logic                far;
      logic [SIGMA_W-1:0]  sigma;
   } pair_type;

endpackage

// ===== design/lj_pair_force_min_image.sv =====
// ----------------------------------------------------------------------------
// lj_pair_force_min_image: Lennard-Jones pair force with minimum image
// Classifies each pair in a short front, queues it, and computes the
// saturated fixed-point force in a long pipeline.
//
//   Channel  Dir  Handshake           Payload
//   req      in   req_tvalid/tready   req_tdata: positions and sigma
//   rsp      out  rsp_tvalid/tready   rsp_tdata: forces, rsp_tuser: flags
//   csr      in   csr_valid/ready     csr_index, csr_data
//
// One pair is taken per cycle while req_tready is high.
// Most of the back pipeline lies in the two pipelined restoring dividers.
// Reset is synchronous, clears all valid bits and sets the configuration registers to defaults.
// A stalled result freezes the back pipeline; the queue keeps the front busy
// until it fills, then req_tready drops.
// ----------------------------------------------------------------------------
module lj_pair_force_min_image
   import lj_pkg::*;
#(
   parameter int FRAC_BITS = LJ_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // first_x, first_y, first_z, second_x, second_y, second_z, pair_sigma
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [215:0]         req_tdata,
   // force_x, force_y, force_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,
   // beyond_cutoff, saturated
   output logic [1:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int LW = $clog2(LJ_QUEUE_DEPTH+1);

   logic [2:0][31:0]  box_ff;
   logic [31:0]       thr_ff;
   logic [31:0]       cutoff_ff;
   logic [EPS_W-1:0]  eps_ff;

   logic              push, pop, empty;
   pair_type          push_data, head;
   logic [LW-1:0]     level;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff    <= {BOX_RESET, BOX_RESET, BOX_RESET};
         thr_ff    <= THR_RESET;
         cutoff_ff <= CUTOFF_RESET;
         eps_ff    <= EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_X:     box_ff[0] <= csr_data;
            CSR_BOX_Y:     box_ff[1] <= csr_data;
            CSR_BOX_Z:     box_ff[2] <= csr_data;
            CSR_THRESHOLD: thr_ff    <= csr_data;
            CSR_CUTOFF:    cutoff_ff <= csr_data;
            CSR_EPSILON:   eps_ff    <= csr_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   lj_front #(.DEPTH(LJ_QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .box        (box_ff),
      .threshold  (thr_ff),
      .cutoff     (cutoff_ff),
      .level      (level),
      .push       (push),
      .push_data  (push_data)
   );

   lj_fifo #(.DEPTH(LJ_QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .level     (level)
   );

   lj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!empty),
      .pop        (pop),
      .cutoff     (cutoff_ff),
      .epsilon    (eps_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A pair beyond the cutoff carries no force and no clamp.
   a_far_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("nonzero force beyond cutoff");

   // A clamp leaves at least one component at a range limit.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata[31:0] == 32'h7FFFFFFF) || (rsp_tdata[31:0] == 32'h80000000) ||
         (rsp_tdata[63:32] == 32'h7FFFFFFF) || (rsp_tdata[63:32] == 32'h80000000) ||
         (rsp_tdata[95:64] == 32'h7FFFFFFF) || (rsp_tdata[95:64] == 32'h80000000))
      else $error("saturation flag without a clamped component");

endmodule

// ===== design/lj_dly.sv =====
// ----------------------------------------------------------------------------
// lj_dly: enabled delay line
// Carries side data alongside the arithmetic units of the back part.
// ----------------------------------------------------------------------------
module lj_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [N];

   // Shift one place on every enabled cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[N-1];

endmodule

// ===== design/lj_mulq.sv =====
// ----------------------------------------------------------------------------
// lj_mulq: two-stage 64 x 64 multiplier
// Four 32 x 32 partial products, then the sum, a fixed-point rescale and a
// saturating 64-bit result.
// ----------------------------------------------------------------------------
module lj_mulq
   import lj_pkg::*;
#(
   parameter int SH = LJ_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [WORD_W-1:0]     a,
   input  logic [WORD_W-1:0]     b,
   output logic [2*WORD_W-1:0]   prod,
   output logic [WORD_W-1:0]     qsat
);

   localparam int HW = WORD_W / 2;

   logic [WORD_W-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic [2*WORD_W-1:0] sum;
   logic [2*WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0]   qsat_ff;

   // Partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[HW-1:0] * b[HW-1:0];
         lh_ff <= a[HW-1:0] * b[WORD_W-1:HW];
         hl_ff <= a[WORD_W-1:HW] * b[HW-1:0];
         hh_ff <= a[WORD_W-1:HW] * b[WORD_W-1:HW];
      end
   end

   assign sum = (2*WORD_W)'(ll_ff) + ((2*WORD_W)'(lh_ff) << HW)
              + ((2*WORD_W)'(hl_ff) << HW) + ((2*WORD_W)'(hh_ff) << WORD_W);

   // Full product and the rescaled, saturated word.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= sum;
         qsat_ff <= (sum[2*WORD_W-1:WORD_W+SH] != '0) ? '1 : sum[WORD_W+SH-1:SH];
      end
   end

   assign prod = prod_ff;
   assign qsat = qsat_ff;

endmodule

// ===== design/lj_div.sv =====
// ----------------------------------------------------------------------------
// lj_div: pipelined restoring divider
// One quotient bit per stage; quotients that do not fit in QW bits saturate
// to all ones, and so does a zero divisor.
// ----------------------------------------------------------------------------
module lj_div #(
   parameter int NW = 128,
   parameter int DW = 64,
   parameter int QW = 64
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int HW = NW - QW;
   localparam int CW = (HW > DW) ? HW : DW;

   logic [CW-1:0] num_hi;
   logic [DW-1:0] rem_ff [QW+1];
   logic [QW-1:0] lo_ff  [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic          sat_ff [QW+1];

   assign num_hi = CW'(num[NW-1:QW]);

   // Overflow check and first partial remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= num_hi >= CW'(den);
         rem_ff[0] <= num_hi[DW-1:0];
         lo_ff[0]  <= num[QW-1:0];
         den_ff[0] <= den;
      end
   end

   // Each stage shifts in one numerator bit and decides one quotient bit.
   for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [DW:0] trial;
      logic        ge;

      assign trial = {rem_ff[i-1], lo_ff[i-1][QW-1]};
      assign ge    = trial >= {1'b0, den_ff[i-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? DW'(trial - {1'b0, den_ff[i-1]}) : trial[DW-1:0];
            lo_ff[i]  <= {lo_ff[i-1][QW-2:0], ge};
            den_ff[i] <= den_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
         end
      end
   end

   assign quo = lo_ff[QW] | {QW{sat_ff[QW]}};

endmodule

// ===== design/lj_fifo.sv =====
// ----------------------------------------------------------------------------
// lj_fifo: short queue between front and back
// Holds classified pairs so that either side can stall on its own.
// ----------------------------------------------------------------------------
module lj_fifo
   import lj_pkg::*;
#(
   parameter int DEPTH = LJ_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pair_type                   push_data,
   input  logic                       pop,
   output pair_type                   head,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH+1);

   pair_type      mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign empty = (level_ff == '0);
   assign level = level_ff;

   // The front must never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && level_ff == LW'(DEPTH)))
      else $error("queue overflow");

   // Popping an empty queue would hand stale data to the back.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && level_ff == '0))
      else $error("queue underflow");

endmodule

// ===== design/lj_front.sv =====
// ----------------------------------------------------------------------------
// lj_front: separation and minimum-image classification
// Two stages: per-axis difference and threshold test, then the box shift,
// magnitude and cutoff test per axis. Entry is gated by queue credits.
// ----------------------------------------------------------------------------
module lj_front
   import lj_pkg::*;
#(
   parameter int DEPTH = LJ_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [215:0]               req_tdata,
   input  logic [2:0][31:0]           box,
   input  logic [31:0]                threshold,
   input  logic [31:0]                cutoff,
   input  logic [$clog2(DEPTH+1)-1:0] level,
   output logic                       push,
   output pair_type                   push_data
);

   localparam int LW = $clog2(DEPTH+1);
   localparam int CRW = LW + 2;

   logic [2:0][32:0]    d1_ff;
   logic [2:0]          over1_ff;
   logic [SIGMA_W-1:0]  sigma1_ff;
   logic                v1_ff;
   pair_type            entry_ff, entry_in;
   logic                v2_ff;
   logic [CRW-1:0]      in_flight;
   logic                accept;

   // Credits: queue contents plus beats still inside the front.
   assign in_flight  = CRW'(level) + CRW'(v1_ff) + CRW'(v2_ff);
   assign req_tready = in_flight < CRW'(DEPTH);
   assign accept     = req_tvalid && req_tready;

   // Stage one: signed difference and the image threshold test.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         logic [32:0] diff;
         logic [31:0] dmag;
         diff = {1'b0, req_tdata[a*POS_W +: POS_W]} - {1'b0, req_tdata[(a+3)*POS_W +: POS_W]};
         dmag = diff[32] ? 32'(-diff) : diff[31:0];
         d1_ff[a]    <= diff;
         over1_ff[a] <= dmag > threshold;
      end
      sigma1_ff <= req_tdata[6*POS_W +: SIGMA_W];
   end

   // Stage two: move the second particle by one box length when needed.
   always_comb begin
      entry_in.far   = 1'b0;
      entry_in.sigma = sigma1_ff;
      for (int a = 0; a < 3; a++) begin
         logic [33:0] dw;
         logic [33:0] dm;
         dw = {d1_ff[a][32], d1_ff[a]};
         if (over1_ff[a]) begin
            dw = d1_ff[a][32] ? dw + {2'b00, box[a]} : dw - {2'b00, box[a]};
         end
         dm = dw[33] ? 34'(-dw) : dw;
         entry_in.neg[a] = dw[33];
         entry_in.mag[a] = dm[31:0];
         if (dm > {2'b00, cutoff}) begin
            entry_in.far = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Valid bits of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   assign push      = v2_ff;
   assign push_data = entry_ff;

endmodule

// ===== design/lj_back.sv =====
// ----------------------------------------------------------------------------
// lj_back: force pipeline
// Squares, r2 and cutoff test, sigma^2 / r2, the u^3 and u^6 terms, the
// epsilon scale and the three per-axis force divisions, then clamping.
// The whole pipeline advances whenever the result register can move.
// ----------------------------------------------------------------------------
module lj_back
   import lj_pkg::*;
#(
   parameter int FRAC_BITS = LJ_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  pair_type            head,
   input  logic                head_valid,
   output logic                pop,
   input  logic [31:0]         cutoff,
   input  logic [EPS_W-1:0]    epsilon,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [95:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   localparam int U_QW   = WORD_W;
   localparam int U_NW   = 2 * WORD_W;
   localparam int F_NW   = 2 * WORD_W + FRAC_BITS;
   localparam int LAT_U  = U_QW + 1;
   localparam int LAT_F  = FORCE_QW + 1;
   localparam int D_MAG  = LAT_U + 3 * MUL_LAT + 1 + MUL_LAT + 1;
   localparam int D_R2   = D_MAG + MUL_LAT;
   localparam int D_TAIL = D_R2 + LAT_F;
   localparam int D_GN   = MUL_LAT + 1 + MUL_LAT + LAT_F;
   localparam logic [WORD_W-1:0] K24_LIMIT = {WORD_W{1'b1}} / 24;

   logic adv;

   // Stage one registers.
   logic [2:0][63:0]   sq1_ff;
   logic [47:0]        sig2_1_ff;
   logic [2:0][31:0]   mag1_ff;
   logic [2:0]         neg1_ff;
   logic               far1_ff;
   logic               v1_ff;
   logic [63:0]        cutsq_ff;

   // Stage two registers.
   logic [65:0]        r2sum;
   logic               far_now;
   logic [63:0]        r2_ff;
   logic               kill2_ff, far2_ff;
   logic [2:0][31:0]   mag2_ff;
   logic [2:0]         neg2_ff;
   logic [47:0]        sig2_2_ff;
   logic               v2_ff;

   // Energy term chain.
   logic [63:0]        u, u_d, uu, u3, u3_d, u6, kq;
   logic [63:0]        two6;
   logic [63:0]        g_ff;
   logic               gneg_ff, gneg_d;
   logic [63:0]        k24_ff;

   // Per-axis force chain.
   logic [2:0][31:0]   mag_d;
   logic [63:0]        r2_d;
   logic [2:0][127:0]  prod;
   logic [2:0][FORCE_QW-1:0] qf;
   logic [4:0]         tail_d;
   logic               kill_d, far_d;
   logic [2:0]         neg_d;

   // Valid chain and result register.
   logic [D_TAIL-1:0]  vq_ff;
   logic               vout_ff;
   logic [95:0]        data_ff;
   logic [1:0]         user_ff;

   assign adv = !vout_ff || rsp_tready;
   assign pop = adv && head_valid;

   // Cutoff squared follows the register.
   always_ff @(posedge clock) begin
      cutsq_ff <= cutoff * cutoff;
   end

   // Stage one: axis squares and sigma squared.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            sq1_ff[a] <= head.mag[a] * head.mag[a];
         end
         sig2_1_ff <= head.sigma * head.sigma;
         mag1_ff   <= head.mag;
         neg1_ff   <= head.neg;
         far1_ff   <= head.far;
      end
   end

   // Stage two: r2 and the exact cutoff comparison.
   assign r2sum   = 66'(sq1_ff[0]) + 66'(sq1_ff[1]) + 66'(sq1_ff[2]);
   assign far_now = far1_ff || (r2sum > 66'(cutsq_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff     <= r2sum[63:0];
         far2_ff   <= far_now;
         kill2_ff  <= far_now || (r2sum == '0);
         mag2_ff   <= mag1_ff;
         neg2_ff   <= neg1_ff;
         sig2_2_ff <= sig2_1_ff;
      end
   end

   // u = sigma^2 / r2.
   lj_div #(.NW(U_NW), .DW(WORD_W), .QW(U_QW)) u_div_u (
      .clock (clock), .en (adv),
      .num   (U_NW'(sig2_2_ff) << FRAC_BITS),
      .den   (r2_ff),
      .quo   (u)
   );

   lj_dly #(.W(WORD_W), .N(MUL_LAT)) u_dly_u (
      .clock (clock), .en (adv), .din (u), .dout (u_d)
   );

   lj_mulq #(.SH(FRAC_BITS)) u_mul_uu (
      .clock (clock), .en (adv), .a (u), .b (u), .prod (), .qsat (uu)
   );

   lj_mulq #(.SH(FRAC_BITS)) u_mul_u3 (
      .clock (clock), .en (adv), .a (uu), .b (u_d), .prod (), .qsat (u3)
   );

   lj_dly #(.W(WORD_W), .N(MUL_LAT)) u_dly_u3 (
      .clock (clock), .en (adv), .din (u3), .dout (u3_d)
   );

   lj_mulq #(.SH(FRAC_BITS)) u_mul_u6 (
      .clock (clock), .en (adv), .a (u3), .b (u3), .prod (), .qsat (u6)
   );

   // g = 2 u^6 - u^3 as magnitude and sign.
   assign two6 = u6[63] ? '1 : {u6[62:0], 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         gneg_ff <= two6 < u3_d;
         g_ff    <= (two6 < u3_d) ? u3_d - two6 : two6 - u3_d;
      end
   end

   lj_mulq #(.SH(FRAC_BITS)) u_mul_k (
      .clock (clock), .en (adv), .a (WORD_W'(epsilon)), .b (g_ff), .prod (), .qsat (kq)
   );

   // Times 24, saturating.
   always_ff @(posedge clock) begin
      if (adv) begin
         k24_ff <= (kq > K24_LIMIT) ? '1 : (kq << 4) + (kq << 3);
      end
   end

   // Side data carried to where it is needed.
   lj_dly #(.W(96), .N(D_MAG)) u_dly_mag (
      .clock (clock), .en (adv), .din (mag2_ff), .dout (mag_d)
   );

   lj_dly #(.W(WORD_W), .N(D_R2)) u_dly_r2 (
      .clock (clock), .en (adv), .din (r2_ff), .dout (r2_d)
   );

   lj_dly #(.W(5), .N(D_TAIL)) u_dly_tail (
      .clock (clock), .en (adv), .din ({kill2_ff, far2_ff, neg2_ff}), .dout (tail_d)
   );

   lj_dly #(.W(1), .N(D_GN)) u_dly_gneg (
      .clock (clock), .en (adv), .din (gneg_ff), .dout (gneg_d)
   );

   assign {kill_d, far_d, neg_d} = tail_d;

   // Per-axis |d| * k * 2^F / r2.
   for (genvar a = 0; a < 3; a++) begin : g_axis
      lj_mulq #(.SH(FRAC_BITS)) u_mul_f (
         .clock (clock), .en (adv), .a (WORD_W'(mag_d[a])), .b (k24_ff),
         .prod  (prod[a]), .qsat ()
      );

      lj_div #(.NW(F_NW), .DW(WORD_W), .QW(FORCE_QW)) u_div_f (
         .clock (clock), .en (adv),
         .num   (F_NW'(prod[a]) << FRAC_BITS),
         .den   (r2_d),
         .quo   (qf[a])
      );
   end

   // Sign, clamp and flags into the result register.
   always_ff @(posedge clock) begin
      if (adv) begin
         logic                sat;
         logic                neg;
         logic [FORCE_QW-1:0] lim;
         logic [FORCE_QW-1:0] qc;
         sat = 1'b0;
         for (int a = 0; a < 3; a++) begin
            neg = neg_d[a] ^ gneg_d;
            lim = neg ? FORCE_QW'(33'h080000000) : FORCE_QW'(33'h07FFFFFFF);
            qc  = qf[a];
            if (qf[a] > lim) begin
               qc  = lim;
               sat = 1'b1;
            end
            data_ff[a*FORCE_W +: FORCE_W] <= kill_d ? '0 :
               (neg ? 32'(-qc[31:0]) : qc[31:0]);
         end
         user_ff <= {sat && !kill_d, far_d};
      end
   end

   // Valid bits follow the data through every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         vq_ff   <= '0;
         vout_ff <= 1'b0;
      end else if (adv) begin
         v1_ff   <= head_valid;
         v2_ff   <= v1_ff;
         vq_ff   <= {vq_ff[D_TAIL-2:0], v2_ff};
         vout_ff <= vq_ff[D_TAIL-1];
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lj_pair_force_min_image
// Drives particle pairs on the request stream and computes the expected
// Lennard-Jones force with minimum-image shift in a bit-exact predictor.
// Every response beat is checked field by field against the oldest
// prediction. Random gaps are placed on both streams and the register
// settings are swept through their extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import lj_pkg::*;

   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_WAIT  = 200;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Predicted response: forces[0] is force_x in the lowest bits.
   typedef struct packed {
      logic             beyond;
      logic             sat;
      logic [2:0][31:0] forces;
   } pair_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [215:0]         req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [95:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   // Register copies used by the predictor.
   logic [31:0] box_len [3];
   logic [31:0] shift_thr;
   logic [31:0] cut_dist;
   logic [23:0] well_depth;

   pair_result_type pending_forces [$];
   int              mismatches;
   int              cycles;
   int              hold_left;
   bit              quiet_rsp;

   lj_pair_force_min_image dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturating fixed-point helpers.
   function automatic logic [63:0] div_clamp(logic [127:0] num, logic [63:0] den);
      logic [127:0] quo;
      quo = num / {64'b0, den};
      return (quo[127:64] != 0) ? ALL_ONES : quo[63:0];
   endfunction

   function automatic logic [63:0] mul_fix(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = ({64'b0, a} * {64'b0, b}) >> LJ_FRAC_BITS;
      return (prod[127:64] != 0) ? ALL_ONES : prod[63:0];
   endfunction

   // Expected force for one pair beat under the current register values.
   function automatic pair_result_type predict_pair_force(logic [215:0] pair);
      pair_result_type res;
      longint       d;
      logic [63:0]  m, r2, u, u3, u6, two6, g, k, q, lim, val, sq;
      logic [64:0]  sum2;
      logic [65:0]  acc;
      logic [63:0]  mag [3];
      logic [2:0]   dneg;
      logic         far, gneg, sat, neg;
      logic [23:0]  sigma;
      res = '0;
      far = 1'b0;
      sat = 1'b0;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
         d = longint'({32'b0, pair[a*32 +: 32]}) - longint'({32'b0, pair[(a+3)*32 +: 32]});
         m = (d < 0) ? -d : d;
         if (m > {32'b0, shift_thr}) begin
            d = (d > 0) ? d - longint'({32'b0, box_len[a]})
                        : d + longint'({32'b0, box_len[a]});
         end
         dneg[a] = (d < 0);
         mag[a] = (d < 0) ? -d : d;
         if (mag[a] > {32'b0, cut_dist}) far = 1'b1;
      end
      if (!far) begin
         for (int a = 0; a < 3; a++) begin
            sq = mag[a] * mag[a];
            acc = acc + {2'b0, sq};
         end
         if (acc > {2'b0, ALL_ONES} || acc[63:0] > {32'b0, cut_dist} * {32'b0, cut_dist})
            far = 1'b1;
      end
      r2 = acc[63:0];
      res.beyond = far;
      if (far || r2 == 0) return res;

      sigma = pair[215:192];
      u = div_clamp({64'b0, {40'b0, sigma} * {40'b0, sigma}} << LJ_FRAC_BITS, r2);
      u3 = mul_fix(mul_fix(u, u), u);
      u6 = mul_fix(u3, u3);
      sum2 = {1'b0, u6} + {1'b0, u6};
      two6 = sum2[64] ? ALL_ONES : sum2[63:0];
      gneg = two6 < u3;
      g = gneg ? u3 - two6 : two6 - u3;
      k = mul_fix({40'b0, well_depth}, g);
      k = (k > ALL_ONES / 24) ? ALL_ONES : k * 24;
      for (int a = 0; a < 3; a++) begin
         q = div_clamp(({64'b0, mag[a]} * {64'b0, k}) << LJ_FRAC_BITS, r2);
         neg = dneg[a] ^ gneg;
         lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (q > lim) begin
            q = lim;
            sat = 1'b1;
         end
         val = neg ? -q : q;
         res.forces[a] = val[31:0];
      end
      res.sat = sat;
      return res;
   endfunction

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Record a prediction for each accepted request beat.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_forces.insert(pending_forces.size(), predict_pair_force(req_tdata));
   end

   // Check each accepted response beat against the oldest prediction.
   always @(posedge clock) begin
      pair_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_forces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            exp_res = pending_forces.pop_front();
            for (int a = 0; a < 3; a++) begin
               if (rsp_tdata[a*32 +: 32] !== exp_res.forces[a]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("force axis %0d: expected %h, got %h", a,
                              exp_res.forces[a], rsp_tdata[a*32 +: 32]);
               end
            end
            if (rsp_tuser[0] !== exp_res.beyond) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beyond_cutoff: expected %b, got %b", exp_res.beyond, rsp_tuser[0]);
            end
            if (rsp_tuser[1] !== exp_res.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("saturated: expected %b, got %b", exp_res.sat, rsp_tuser[1]);
            end
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side: random stalls, a long hold-off on request.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (quiet_rsp) begin
            rsp_tready = 1'b1;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            stall = pick_gap();
            rsp_tready = (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   // Send one pair beat, then an optional gap.
   task automatic send_pair(logic [215:0] pair, bit no_gaps);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = pair;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic end_burst();
      req_tvalid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BOX_X:     box_len[0] = value;
         CSR_BOX_Y:     box_len[1] = value;
         CSR_BOX_Z:     box_len[2] = value;
         CSR_THRESHOLD: shift_thr  = value;
         CSR_CUTOFF:    cut_dist   = value;
         CSR_EPSILON:   well_depth = value[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                            logic [31:0] thr, logic [31:0] cut, logic [31:0] eps);
      wait_idle();
      write_reg(CSR_BOX_X, bx);
      write_reg(CSR_BOX_Y, by);
      write_reg(CSR_BOX_Z, bz);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_CUTOFF, cut);
      write_reg(CSR_EPSILON, eps);
   endtask

   function automatic logic [215:0] make_pair(logic [31:0] fx, logic [31:0] fy,
                                              logic [31:0] fz, logic [31:0] sx,
                                              logic [31:0] sy, logic [31:0] sz,
                                              logic [23:0] sig);
      return {sig, sz, sy, sx, fz, fy, fx};
   endfunction

   // Mostly close pairs (some across a box edge), the rest raw noise.
   function automatic logic [215:0] random_pair();
      logic [31:0] first [3];
      logic [31:0] second [3];
      longint      span, delta;
      logic [23:0] sig;
      span = (cut_dist > 32'h0010_0000) ? 64'h0010_0000 : {32'b0, cut_dist};
      if ($urandom_range(0, 99) < 30)
         return 216'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom()});
      for (int a = 0; a < 3; a++) begin
         first[a] = $urandom();
         delta = longint'($urandom_range(0, 32'(2 * span))) - span;
         if ($urandom_range(0, 3) == 0)
            delta = ($urandom_range(0, 1) != 0) ? delta + box_len[a] : delta - box_len[a];
         second[a] = first[a] - delta[31:0];
      end
      sig = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(32768, 131072))
                                       : 24'($urandom());
      return make_pair(first[0], first[1], first[2], second[0], second[1], second[2], sig);
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_pair(random_pair(), 1'b0);
      end_burst();
   endtask

   // Corner pairs under the reset register values.
   task automatic test_directed();
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_pair(make_pair('1, '1, '1, '1, '1, '1, '1), 1'b0);
      send_pair(make_pair(32'h5_0000 + 65536, 32'h5_0000, 32'h5_0000,
                          32'h5_0000, 32'h5_0000, 32'h5_0000, 24'h01_0000), 1'b0);
      send_pair(make_pair(100, 32'h3_0000, 100, 100, 32'h4_0000, 100, 24'h01_0000), 1'b0);
      send_pair(make_pair(0, 0, 32'h8000, 0, 0, 0, 24'hFF_FFFF), 1'b0);
      send_pair(make_pair(32'h2_0000, 0, 0, 0, 0, 0, 24'h01_0000), 1'b0);
      send_pair(make_pair(32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 24'h01_0000), 1'b0);
      send_pair(make_pair(98304, 0, 0, 0, 0, 0, 24'h01_0000), 1'b0);
      send_pair(make_pair(32'h9_8000, 7, 7, 32'h0_8000, 7, 7, 24'h01_0000), 1'b0);
      send_pair(make_pair(9, 32'h0_8000, 9, 9, 32'h9_8000, 9, 24'h01_0000), 1'b0);
      send_pair(make_pair(5, 5, 32'h9_C000, 5, 5, 32'h0_4000, 24'h01_0000), 1'b0);
      send_pair(make_pair(32'h1_0000, 0, 0, 0, 0, 0, 24'h00_0000), 1'b0);
      send_pair(make_pair(0, 0, 0, '1, '1, '1, 24'h01_0000), 1'b0);
      send_pair(make_pair(1, 0, 0, 0, 0, 0, 24'h01_0000), 1'b0);
      send_pair(make_pair(32'hE666, 32'hE666, 0, 0, 0, 0, 24'h01_0000), 1'b0);
      send_pair(make_pair(32'h1_2000, 32'h8000, 32'h4000, 0, 0, 0, 24'h00_C000), 1'b0);
      end_burst();
   endtask

   task automatic test_random_default();
      send_random(350);
      quiet_rsp = 1'b1;
      for (int i = 0; i < 100; i++) send_pair(random_pair(), 1'b1);
      end_burst();
      quiet_rsp = 1'b0;
      send_random(250);
   endtask

   // Hold the response side off while requests keep coming.
   task automatic test_backpressure();
      hold_left = 400;
      for (int i = 0; i < 150; i++) send_pair(random_pair(), 1'b1);
      end_burst();
   endtask

   task automatic test_register_sweep();
      write_all('1, '1, '1, 0, '1, 32'h00FF_FFFF);
      send_random(150);
      write_all(1, 1, 0, '1, 0, 0);
      send_random(80);
      send_pair(make_pair(3, 3, 3, 3, 3, 3, 24'h01_0000), 1'b0);
      end_burst();
      write_all(32'h4_0000, 32'h6_0000, 32'h3_0000, 32'h1_0000, 32'h3_0000, 0);
      send_random(80);
      write_all($urandom_range(1, 32'h0020_0000), $urandom_range(1, 32'h0020_0000),
                $urandom_range(1, 32'h0020_0000), $urandom_range(0, 32'h0010_0000),
                $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h00FF_FFFF));
      send_random(150);
      write_all(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0008_0000,
                $urandom(), $urandom());
      send_random(100);
      write_all(BOX_RESET, BOX_RESET, BOX_RESET, THR_RESET, CUTOFF_RESET, {8'b0, EPS_RESET});
      send_random(50);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_BOX_X;
      csr_data    = '0;
      mismatches  = 0;
      cycles      = 0;
      hold_left   = 0;
      quiet_rsp   = 1'b0;
      box_len[0]  = BOX_RESET;
      box_len[1]  = BOX_RESET;
      box_len[2]  = BOX_RESET;
      shift_thr   = THR_RESET;
      cut_dist    = CUTOFF_RESET;
      well_depth  = EPS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_default();
      test_backpressure();
      test_register_sweep();

      wait_idle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== lj_pair_force_min_image.f =====
design/lj_pkg.sv
design/lj_dly.sv
design/lj_mulq.sv
design/lj_div.sv
design/lj_fifo.sv
design/lj_front.sv
design/lj_back.sv
design/lj_pair_force_min_image.sv
test/testbench.sv
